// ===== rtl/eip_pkg.sv =====
// Shared types and constants for the Ethernet/IPv4 port extractor.
`timescale 1ns / 1ps

package eip_pkg;

	localparam int unsigned POS_W = 7;
	localparam logic [POS_W-1:0] POS_MAX = 7'd127;

	localparam logic [POS_W-1:0] POS_KIND_HI = 7'd12;
	localparam logic [POS_W-1:0] POS_KIND_LO = 7'd13;
	localparam logic [POS_W-1:0] POS_IHL = 7'd14;
	localparam logic [POS_W-1:0] POS_PROTO = 7'd23;
	localparam logic [POS_W-1:0] POS_ADDR_FIRST = 7'd26;
	localparam logic [POS_W-1:0] POS_ADDR_LAST = 7'd29;

	localparam logic [7:0] ETH_LEN = 8'd14;
	localparam logic [7:0] IP_MIN_END = 8'd34;
	localparam logic [7:0] L4_LEN = 8'd8;
	localparam logic [3:0] IHL_MIN = 4'd5;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam int unsigned OUT_BYTES = 12;

	typedef enum logic [2:0] {
		ST_PARSED = 3'd0,
		ST_SHORT_ETH = 3'd1,
		ST_SHORT_IP = 3'd2,
		ST_SHORT_L4 = 3'd3,
		ST_OTHER_PROTO = 3'd4,
		ST_BAD_IHL = 3'd5
	} status_t;

	typedef struct packed {
		logic [15:0] dest_port;
		logic [15:0] source_port;
		logic [31:0] source_address;
		logic [7:0] ip_protocol;
		logic [15:0] ether_kind;
		status_t parse_status;
	} result_t;

	function automatic logic is_tcp_or_udp(input logic [7:0] p);
		return (p == PROTO_TCP) || (p == PROTO_UDP);
	endfunction

endpackage

// ===== rtl/eip_field_capture.sv =====
// Per-frame byte position, field capture and end-of-frame status.
`timescale 1ns / 1ps

module eip_field_capture (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          pkt_byte,
	input  logic                last,
	output logic                res_valid,
	output eip_pkg::result_t    res
);

	logic [eip_pkg::POS_W-1:0] pos_q;
	logic [15:0] kind_q;
	logic [3:0]  hw_q;
	logic [7:0]  proto_q;
	logic [31:0] addr_q;
	logic [15:0] sport_q;
	logic [15:0] dport_q;

	logic [15:0] kind_d;
	logic [3:0]  hw_d;
	logic [7:0]  proto_d;
	logic [31:0] addr_d;
	logic [15:0] sport_d;
	logic [15:0] dport_d;
	logic [eip_pkg::POS_W-1:0] pos_inc;
	logic [8:0]  l4_sum;
	logic [eip_pkg::POS_W-1:0] l4_pos;
	logic        port_en;
	logic [7:0]  len;
	logic [7:0]  l4_end;

	// L4 header offset from the stored header length
	assign l4_sum = {3'b000, hw_q, 2'b00} + {1'b0, eip_pkg::ETH_LEN};
	assign l4_pos = l4_sum[eip_pkg::POS_W-1:0];
	assign port_en = (pos_q > eip_pkg::POS_IHL) && (hw_q >= eip_pkg::IHL_MIN)
		&& eip_pkg::is_tcp_or_udp(proto_q);
	assign pos_inc = (pos_q < eip_pkg::POS_MAX) ? pos_q + 7'd1 : pos_q;

	always_comb begin
		kind_d = kind_q;
		hw_d = hw_q;
		proto_d = proto_q;
		addr_d = addr_q;
		sport_d = sport_q;
		dport_d = dport_q;
		if (pos_q == eip_pkg::POS_KIND_HI || pos_q == eip_pkg::POS_KIND_LO) begin
			kind_d = {kind_q[7:0], pkt_byte};
		end else if (pos_q == eip_pkg::POS_IHL) begin
			hw_d = pkt_byte[3:0];
		end else if (pos_q == eip_pkg::POS_PROTO) begin
			proto_d = pkt_byte;
		end else if (pos_q >= eip_pkg::POS_ADDR_FIRST && pos_q <= eip_pkg::POS_ADDR_LAST) begin
			addr_d = {addr_q[23:0], pkt_byte};
		end
		if (port_en) begin
			if (pos_q == l4_pos || pos_q == l4_pos + 7'd1) begin
				sport_d = {sport_q[7:0], pkt_byte};
			end else if (pos_q == l4_pos + 7'd2 || pos_q == l4_pos + 7'd3) begin
				dport_d = {dport_q[7:0], pkt_byte};
			end
		end
	end

	// End-of-frame verdict from the fields as updated by this byte
	assign len = {1'b0, pos_q} + 8'd1;
	assign l4_end = {1'b0, l4_pos} + eip_pkg::L4_LEN;

	always_comb begin
		res = '0;
		res.parse_status = eip_pkg::ST_PARSED;
		if (len < eip_pkg::ETH_LEN) begin
			res.parse_status = eip_pkg::ST_SHORT_ETH;
		end else begin
			res.ether_kind = kind_d;
			if (len < eip_pkg::IP_MIN_END) begin
				res.parse_status = eip_pkg::ST_SHORT_IP;
			end else begin
				res.ip_protocol = proto_d;
				res.source_address = addr_d;
				if (hw_d < eip_pkg::IHL_MIN) begin
					res.parse_status = eip_pkg::ST_BAD_IHL;
				end else if (!eip_pkg::is_tcp_or_udp(proto_d)) begin
					res.parse_status = eip_pkg::ST_OTHER_PROTO;
				end else if (len < l4_end) begin
					res.parse_status = eip_pkg::ST_SHORT_L4;
				end else begin
					res.source_port = sport_d;
					res.dest_port = dport_d;
				end
			end
		end
	end

	assign res_valid = advance & last;

	// Clear everything at frame end, otherwise take the updated fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			kind_q <= '0;
			hw_q <= '0;
			proto_q <= '0;
			addr_q <= '0;
			sport_q <= '0;
			dport_q <= '0;
		end else if (advance) begin
			if (last) begin
				pos_q <= '0;
				kind_q <= '0;
				hw_q <= '0;
				proto_q <= '0;
				addr_q <= '0;
				sport_q <= '0;
				dport_q <= '0;
			end else begin
				pos_q <= pos_inc;
				kind_q <= kind_d;
				hw_q <= hw_d;
				proto_q <= proto_d;
				addr_q <= addr_d;
				sport_q <= sport_d;
				dport_q <= dport_d;
			end
		end
	end

endmodule

// ===== rtl/eip_out_reg.sv =====
// Result register driving the master-side stream.
`timescale 1ns / 1ps

module eip_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  eip_pkg::result_t res,
	input  logic             take,
	output logic             valid,
	output eip_pkg::result_t data
);

	logic valid_q;
	eip_pkg::result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign valid = valid_q;
	assign data = res_q;

endmodule

// ===== rtl/eth_ipv4_port_extractor.sv =====
// Top level of the Ethernet/IPv4 header field and L4 port extractor.
`timescale 1ns / 1ps

// Takes a frame one byte per transaction on the slave side, s_tlast on the
// final byte, and returns one result transaction per frame on the master side.
// Throughput is one byte per cycle while the slave side is not stalled: each
// byte sits in an input register while the capture logic compares its
// position and updates the frame fields, and the frame-end byte loads the
// result register, from which the result is offered on m_tvalid. The slave
// side stalls only when a frame-end byte waits in the input register and the
// result register still holds an untaken result. Status codes: parsed, short
// Ethernet, short IPv4, short L4, protocol neither TCP nor UDP, and IPv4
// header length below five words; fields not reached in the frame read zero,
// ports are nonzero only for a parsed frame. The ethertype is reported but
// not checked, so any frame is interpreted with IPv4 offsets.
module eth_ipv4_port_extractor (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] packet_byte
	input  logic         s_tlast,   // frame_end
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata    // [2:0] parse_status, [18:3] ether_kind,
	                                // [26:19] ip_protocol, [58:27] source_address,
	                                // [74:59] source_port, [90:75] dest_port,
	                                // [95:91] zero
);

	logic       in_valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;
	logic       res_valid;
	eip_pkg::result_t res;
	eip_pkg::result_t out_data;

	// Advance the held byte unless it ends a frame and the result slot is busy
	assign advance = in_valid_s1 && (!last_s1 || !m_tvalid || m_tready);
	assign s_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	// Hold the payload while stalled
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	eip_field_capture u_capture (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.pkt_byte (byte_s1),
		.last     (last_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	eip_out_reg u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (res_valid),
		.res   (res),
		.take  (m_tready),
		.valid (m_tvalid),
		.data  (out_data)
	);

	assign m_tdata = {5'b00000, out_data.dest_port, out_data.source_port,
		out_data.source_address, out_data.ip_protocol, out_data.ether_kind,
		out_data.parse_status};

`ifndef SYNTHESIS
	// A new result never overwrites one that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!m_tvalid || m_tready))
		else $error("result register overwritten");

	// A short Ethernet frame reports no captured fields
	a_short_eth_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_data.parse_status == eip_pkg::ST_SHORT_ETH) |->
		(out_data.ether_kind == '0 && out_data.ip_protocol == '0 &&
		out_data.source_address == '0 && out_data.source_port == '0 &&
		out_data.dest_port == '0))
		else $error("short Ethernet frame with captured fields");

	// A parsed frame always carries TCP or UDP
	a_parsed_proto: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_data.parse_status == eip_pkg::ST_PARSED) |->
		(out_data.ip_protocol == eip_pkg::PROTO_TCP ||
		out_data.ip_protocol == eip_pkg::PROTO_UDP))
		else $error("parsed frame with other protocol");
`endif

endmodule

// ===== tb/eth_ipv4_port_extractor_tb.sv =====
// Testbench for the Ethernet/IPv4 header and port extractor: streamed frames, predicted results.
`timescale 1ns / 1ps

module eth_ipv4_port_extractor_tb;

	// Frame layout, counted in byte positions from the start of the frame
	localparam int ETH_HDR_LEN = 14;
	localparam int IP_HDR_END = 34;
	localparam int L4_HDR_LEN = 8;
	localparam int KIND_HI_POS = 12;
	localparam int KIND_LO_POS = 13;
	localparam int IHL_POS = 14;
	localparam int PROTO_POS = 23;
	localparam int ADDR_FIRST_POS = 26;
	localparam int ADDR_LAST_POS = 29;
	localparam int MIN_WORDS = 5;
	localparam logic [6:0] POS_SAT = 7'd127;
	localparam logic [7:0] TCP_NUM = 8'd6;
	localparam logic [7:0] UDP_NUM = 8'd17;

	localparam int IDLE_PCT = 13;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		logic [7:0] data;
		logic last;
	} frame_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [95:0] m_tdata;

	frame_byte_t frame_bytes[$];
	eip_pkg::result_t expected_headers[$];

	// Capture state of the frame being tracked
	logic [6:0] byte_pos = '0;
	logic [15:0] cap_kind = '0;
	logic [3:0] cap_words = '0;
	logic [7:0] cap_proto = '0;
	logic [31:0] cap_addr = '0;
	logic [15:0] cap_sport = '0;
	logic [15:0] cap_dport = '0;

	int bytes_queued = 0;
	int bytes_accepted = 0;
	int results_pending = 0;
	int error_count = 0;
	int quiet_cycles = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	bit no_idle = 1'b0;

	eth_ipv4_port_extractor uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #10 clk = ~clk;

	// Advance the tracked frame by one byte; on the frame end, queue the
	// header summary the block must return and clear for the next frame.
	task automatic track_frame_byte(input logic [7:0] b, input logic last, output bit made);
		int pos;
		int l4_pos;
		int len;
		bit ports_valid;
		eip_pkg::result_t r;
		pos = int'(byte_pos);
		l4_pos = ETH_HDR_LEN + 4 * int'(cap_words);
		made = 1'b0;

		if (pos == KIND_HI_POS || pos == KIND_LO_POS) begin
			cap_kind = {cap_kind[7:0], b};
		end else if (pos == IHL_POS) begin
			cap_words = b[3:0];
		end else if (pos == PROTO_POS) begin
			cap_proto = b;
		end else if (pos >= ADDR_FIRST_POS && pos <= ADDR_LAST_POS) begin
			cap_addr = {cap_addr[23:0], b};
		end

		ports_valid = (cap_proto == TCP_NUM) || (cap_proto == UDP_NUM);
		if (pos > IHL_POS && cap_words >= MIN_WORDS && ports_valid) begin
			if (pos == l4_pos || pos == l4_pos + 1) begin
				cap_sport = {cap_sport[7:0], b};
			end else if (pos == l4_pos + 2 || pos == l4_pos + 3) begin
				cap_dport = {cap_dport[7:0], b};
			end
		end

		if (byte_pos < POS_SAT) begin
			byte_pos = byte_pos + 7'd1;
		end

		if (last) begin
			len = pos + 1;
			r = '0;
			if (len < ETH_HDR_LEN) begin
				r.parse_status = eip_pkg::ST_SHORT_ETH;
			end else begin
				r.ether_kind = cap_kind;
				if (len < IP_HDR_END) begin
					r.parse_status = eip_pkg::ST_SHORT_IP;
				end else begin
					r.ip_protocol = cap_proto;
					r.source_address = cap_addr;
					if (cap_words < MIN_WORDS) begin
						r.parse_status = eip_pkg::ST_BAD_IHL;
					end else if (!ports_valid) begin
						r.parse_status = eip_pkg::ST_OTHER_PROTO;
					end else if (len < l4_pos + L4_HDR_LEN) begin
						r.parse_status = eip_pkg::ST_SHORT_L4;
					end else begin
						r.parse_status = eip_pkg::ST_PARSED;
						r.source_port = cap_sport;
						r.dest_port = cap_dport;
					end
				end
			end
			expected_headers.push_back(r);
			made = 1'b1;
			byte_pos = '0;
			cap_kind = '0;
			cap_words = '0;
			cap_proto = '0;
			cap_addr = '0;
			cap_sport = '0;
			cap_dport = '0;
		end
	endtask

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endtask

	// Queue one frame of len bytes; the IHL nibble and protocol byte are
	// forced, every other byte is random or the fill value.
	task automatic queue_frame(input int len, input logic [3:0] ihl, input logic [7:0] proto,
			input bit rnd, input logic [7:0] fillv);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = rnd ? 8'($urandom) : fillv;
			if (i == IHL_POS) begin
				b[3:0] = ihl;
			end
			if (i == PROTO_POS) begin
				b = proto;
			end
			frame_bytes.push_back('{data: b, last: (i == len - 1)});
		end
		bytes_queued += len;
	endtask

	// Hold until every queued byte is taken and every result has come back
	task automatic wait_drained();
		do begin
			@(posedge clk);
		end while (bytes_accepted != bytes_queued || results_pending != 0);
		@(negedge clk);
	endtask

	task automatic wait_accepted(input int target);
		while (bytes_accepted < target) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Sender: hold the current transaction until taken, then advance from the queue
	always @(posedge clk or negedge arst_n) begin : drive_proc
		frame_byte_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
			s_tlast <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (frame_bytes.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
				nxt = frame_bytes.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= nxt.data;
				s_tlast <= nxt.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure, plus a long hold-off on each request
	always @(posedge clk or negedge arst_n) begin : sink_proc
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Monitor: predict on each input transaction, check each result transaction
	always @(posedge clk or negedge arst_n) begin : monitor_proc
		int pend;
		bit made;
		eip_pkg::result_t got;
		eip_pkg::result_t want;
		if (!arst_n) begin
			bytes_accepted <= 0;
			results_pending <= 0;
		end else begin
			pend = results_pending;
			if (s_tvalid && s_tready) begin
				bytes_accepted <= bytes_accepted + 1;
				track_frame_byte(s_tdata, s_tlast, made);
				if (made) begin
					pend++;
				end
			end
			if (m_tvalid && m_tready) begin
				got = eip_pkg::result_t'(m_tdata[90:0]);
				if (expected_headers.size() == 0) begin
					$error("unexpected result transaction: %h", m_tdata);
					error_count++;
				end else begin
					want = expected_headers.pop_front();
					pend--;
					check_field("parse_status", want.parse_status, got.parse_status);
					check_field("ether_kind", want.ether_kind, got.ether_kind);
					check_field("ip_protocol", want.ip_protocol, got.ip_protocol);
					check_field("source_address", want.source_address, got.source_address);
					check_field("source_port", want.source_port, got.source_port);
					check_field("dest_port", want.dest_port, got.dest_port);
					check_field("pad", 0, m_tdata[95:91]);
				end
			end
			results_pending <= pend;
		end
	end

	// Abort when neither side moves a transaction for too long
	always @(posedge clk) begin : watchdog_proc
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stim_proc
		int rnd_bytes;
		int sel;
		int ihl_v;
		int len_v;
		int min_len;
		int base;
		logic [7:0] proto_v;
		rnd_bytes = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed frames: length thresholds, header length and protocol cases
		queue_frame(1, 4'd0, 8'd0, 1'b1, 8'h00);        // frame end on the first byte
		queue_frame(13, 4'd5, TCP_NUM, 1'b1, 8'h00);    // one short of an Ethernet header
		queue_frame(14, 4'd5, TCP_NUM, 1'b1, 8'h00);    // Ethernet only
		queue_frame(33, 4'd5, TCP_NUM, 1'b1, 8'h00);    // one short of IPv4
		queue_frame(34, 4'd0, 8'd0, 1'b0, 8'h00);       // all zeros, zero header length
		queue_frame(34, 4'd4, UDP_NUM, 1'b1, 8'h00);    // header length just below five
		queue_frame(34, 4'd5, 8'd1, 1'b1, 8'h00);       // neither TCP nor UDP
		queue_frame(41, 4'd5, TCP_NUM, 1'b1, 8'h00);    // one short of the ports
		queue_frame(42, 4'd5, TCP_NUM, 1'b1, 8'h00);    // smallest parsed frame
		queue_frame(42, 4'd5, UDP_NUM, 1'b0, 8'hFF);    // all other bytes ones: kind, address and ports at maximum
		queue_frame(81, 4'd15, UDP_NUM, 1'b1, 8'h00);   // largest header, one short
		queue_frame(82, 4'd15, TCP_NUM, 1'b1, 8'h00);   // largest header, parsed
		queue_frame(200, 4'd5, TCP_NUM, 1'b1, 8'h00);   // position saturates
		queue_frame(130, 4'd15, 8'hFF, 1'b0, 8'hFF);    // all ones, long
		// Stop sending until every result is back
		wait_drained();

		// Long receiver hold-off while the sender keeps offering bytes
		hold_req++;
		base = bytes_queued;
		while (rnd_bytes < 720) begin
			sel = $urandom_range(0, 99);
			ihl_v = 5;
			proto_v = $urandom_range(0, 1) ? TCP_NUM : UDP_NUM;
			if ($urandom_range(0, 3) == 0) begin
				ihl_v = $urandom_range(5, 15);
			end
			min_len = ETH_HDR_LEN + 4 * ihl_v + L4_HDR_LEN;
			if (sel < 70) begin
				len_v = ($urandom_range(0, 14) == 0) ? $urandom_range(128, 220)
					: min_len + $urandom_range(0, 24);
			end else if (sel < 80) begin
				len_v = $urandom_range(IP_HDR_END, min_len - 1);
			end else if (sel < 88) begin
				proto_v = 8'($urandom);
				len_v = $urandom_range(IP_HDR_END, 90);
			end else if (sel < 94) begin
				ihl_v = $urandom_range(0, 4);
				len_v = $urandom_range(IP_HDR_END, 90);
			end else begin
				len_v = $urandom_range(1, IP_HDR_END - 1);
			end
			queue_frame(len_v, 4'(ihl_v), proto_v, 1'b1, 8'h00);
			rnd_bytes += len_v;
		end

		// Run a stretch with no idling on either side
		wait_accepted(base + rnd_bytes / 3);
		no_idle = 1'b1;
		wait_accepted(base + (2 * rnd_bytes) / 3);
		no_idle = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
